>>> hw/rtl/gbnm_pkg.sv
// Package: shared constants, types and codes of the glyph block nearest match.
package gbnm_pkg;
	localparam int BLOCK_PIXELS = 64;
	localparam int MAX_GLYPHS = 128;
	localparam int PIX_W = $clog2(BLOCK_PIXELS);
	localparam int GLY_W = $clog2(MAX_GLYPHS);
	localparam int PSTORE_DEPTH = MAX_GLYPHS * BLOCK_PIXELS;
	localparam int PSTORE_AW = $clog2(PSTORE_DEPTH);
	localparam int SUM_W = 22;
	localparam int CODE_W = 21;
	localparam int MEAN_W = 16;
	localparam int CNT_W = 12;
	localparam int USE_W = 8;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam int GCNT_W = GLY_W + 1;

	localparam logic [CMD_W-1:0] CMD_LOAD_PIXEL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_CODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SOURCE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPHS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_ROW = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [6:0] glyph_index;
		logic [5:0] pixel_index;
		logic [7:0] pixel_value;
		logic [CODE_W-1:0] code_point;
		logic block_last;
		logic picture_start;
	} in_word_t;

	typedef struct packed {
		logic [6:0] best_glyph;
		logic [CODE_W-1:0] best_code_point;
		logic [MEAN_W-1:0] mean_error;
		logic new_line;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACCUM, ST_DRAIN, ST_PICK, ST_SETTLE, ST_CODE, ST_SEND
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic take_in;
		logic sweep_start;
		logic sweep_step;
		logic pick_clear;
		logic code_read;
		logic code_latch;
		logic out_load;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic last_glyph;
		logic pipe_empty;
	} sts_t;
endpackage

>>> hw/rtl/gbnm_if.sv
// Interfaces: valid/ready word channels and the configuration write channel.
interface gbnm_in_if (input logic clk);
	logic valid;
	logic ready;
	gbnm_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gbnm_out_if (input logic clk);
	logic valid;
	logic ready;
	gbnm_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gbnm_cfg_if (input logic clk);
	logic valid;
	logic ready;
	logic [gbnm_pkg::CFG_IDX_W-1:0] index;
	logic [gbnm_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/glyph_block_nearest_match.sv
// Top level: glyph block nearest match, controller plus datapath.
//
// Usage: load glyph pixels (command 0) and code points (command 1) on the
// input channel, then stream source pixels (command 2). Registers must be
// set on the cfg channel while the block is idle, which the block does not
// enforce: index 0 glyphs in use, index 1 blocks per row.
// Sequence: a load word taken in idle goes straight into its store. A source
// pixel sweeps every glyph in use through the sum memory, one glyph a cycle,
// then drains the accumulate pipeline before the next word is accepted. The
// last pixel of a block adds a pick sweep over the glyphs in use, a settle
// state for the choice, a code point fetch and the output register load.
// The sum memory sets the rate.
// Reset: control state, the row count and the sum valid bits clear at once;
// no clearing pass is run. The glyph stores hold nothing defined until
// written.
// Stall: the result waits in the output register; the block holds in its
// send state only if a new result is ready while the previous one is still
// untaken.
module glyph_block_nearest_match (
	input logic clk,
	input logic arst_n,
	gbnm_in_if.sink in_ch,
	gbnm_out_if.source out_ch,
	gbnm_cfg_if.sink cfg
);
	gbnm_pkg::cmd_t cmd;
	gbnm_pkg::sts_t sts;
	gbnm_pkg::out_word_t res_word;
	logic [gbnm_pkg::USE_W-1:0] glyphs_in_use_q;
	logic [gbnm_pkg::CNT_W-1:0] blocks_per_row_q;
	logic out_valid_q;

	// Config writes are always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyphs_in_use_q <= gbnm_pkg::USE_W'(128);
			blocks_per_row_q <= gbnm_pkg::CNT_W'(80);
		end else if (cfg.valid) begin
			case (cfg.index)
				gbnm_pkg::REG_GLYPHS_IN_USE: glyphs_in_use_q <= cfg.data[gbnm_pkg::USE_W-1:0];
				gbnm_pkg::REG_BLOCKS_PER_ROW: blocks_per_row_q <= cfg.data;
				default: ;
			endcase
		end
	end

	gbnm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid),
		.in_is_source(in_ch.data.command == gbnm_pkg::CMD_SOURCE),
		.in_last(in_ch.data.block_last), .out_busy(out_valid_q && !out_ch.ready),
		.sts(sts), .in_ready(in_ch.ready), .cmd(cmd));

	gbnm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_ch.data),
		.glyphs_in_use(glyphs_in_use_q), .blocks_per_row(blocks_per_row_q),
		.sts(sts), .out_word(res_word));

	// Output register: hold the word until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = res_word;

	// A result is only loaded when the register is free or being drained.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ch.ready))
		else $error("result overwritten");
	// No input is taken while a sweep is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |-> !in_ch.ready)
		else $error("input taken mid sweep");
	// The output valid rises only after an output load command.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("spurious result");
endmodule

>>> hw/rtl/gbnm_ram.sv
// Generic single-port-write, registered-read RAM.
module gbnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/gbnm_ctrl.sv
// Controller: takes loads when idle, sweeps source words to accumulate or pick.
module gbnm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_is_source,
	input logic in_last,
	input logic out_busy,
	input gbnm_pkg::sts_t sts,
	output logic in_ready,
	output gbnm_pkg::cmd_t cmd
);
	gbnm_pkg::state_t state_q, state_d;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbnm_pkg::ST_IDLE;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				last_q <= in_last;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			gbnm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take_in = in_valid;
				if (in_valid && in_is_source) begin
					cmd.sweep_start = 1'b1;
					state_d = gbnm_pkg::ST_ACCUM;
				end
			end
			gbnm_pkg::ST_ACCUM: begin
				cmd.sweep_step = 1'b1;
				if (sts.last_glyph) begin
					state_d = gbnm_pkg::ST_DRAIN;
				end
			end
			gbnm_pkg::ST_DRAIN: begin
				if (sts.pipe_empty) begin
					if (last_q) begin
						cmd.sweep_start = 1'b1;
						cmd.pick_clear = 1'b1;
						state_d = gbnm_pkg::ST_PICK;
					end else begin
						state_d = gbnm_pkg::ST_IDLE;
					end
				end
			end
			gbnm_pkg::ST_PICK: begin
				cmd.sweep_step = 1'b1;
				if (sts.last_glyph) begin
					state_d = gbnm_pkg::ST_SETTLE;
				end
			end
			// Let the last glyph's compare land before the code fetch.
			gbnm_pkg::ST_SETTLE: begin
				state_d = gbnm_pkg::ST_CODE;
			end
			gbnm_pkg::ST_CODE: begin
				cmd.code_read = 1'b1;
				state_d = gbnm_pkg::ST_SEND;
			end
			gbnm_pkg::ST_SEND: begin
				if (!out_busy) begin
					cmd.code_latch = 1'b1;
					cmd.out_load = 1'b1;
					state_d = gbnm_pkg::ST_IDLE;
				end
			end
			default: state_d = gbnm_pkg::ST_IDLE;
		endcase
	end
endmodule

>>> hw/rtl/gbnm_dp.sv
// Datapath: glyph stores, error sums, minimum search and row counter.
module gbnm_dp (
	input logic clk,
	input logic arst_n,
	input gbnm_pkg::cmd_t cmd,
	input gbnm_pkg::in_word_t in_word,
	input logic [gbnm_pkg::USE_W-1:0] glyphs_in_use,
	input logic [gbnm_pkg::CNT_W-1:0] blocks_per_row,
	output gbnm_pkg::sts_t sts,
	output gbnm_pkg::out_word_t out_word
);
	localparam int GW = gbnm_pkg::GLY_W;
	localparam int PW = gbnm_pkg::PIX_W;
	localparam int SW = gbnm_pkg::SUM_W;

	gbnm_pkg::in_word_t word_q;
	logic [GW-1:0] g_q;
	logic [gbnm_pkg::GCNT_W-1:0] n_glyphs;
	logic pix_ok_q;
	// Accumulate pipeline: s1 reads store and sum, s2 squares and writes.
	logic v_s1, v_s2;
	logic [GW-1:0] g_s1, g_s2;
	logic [7:0] pv_s1;
	logic [7:0] gp_rd, diff_s2;
	logic [SW-1:0] sum_rd, sum_s2;
	logic [SW:0] sum_new;
	logic [15:0] sq;
	// Pick stage.
	logic pick_q;
	logic p_s1;
	logic [GW-1:0] best_q;
	logic [SW-PW-1:0] best_mean_q;
	logic [SW-PW-1:0] mean_rd;
	logic best_any_q;
	logic [gbnm_pkg::CODE_W-1:0] code_rd;
	logic [gbnm_pkg::CNT_W-1:0] bcount_q, row_len;
	logic pstore_we, cstore_we, sum_we;
	logic [SW-1:0] sum_wdata;
	logic [GW-1:0] sum_waddr, sum_raddr, code_raddr;
	logic [gbnm_pkg::PSTORE_AW-1:0] p_waddr, p_raddr;
	logic sum_valid_q [gbnm_pkg::MAX_GLYPHS];
	logic sum_ok_s1;

	always_comb begin
		if (glyphs_in_use == '0) n_glyphs = gbnm_pkg::GCNT_W'(1);
		else if (glyphs_in_use > gbnm_pkg::USE_W'(gbnm_pkg::MAX_GLYPHS))
			n_glyphs = gbnm_pkg::GCNT_W'(gbnm_pkg::MAX_GLYPHS);
		else n_glyphs = gbnm_pkg::GCNT_W'(glyphs_in_use);
	end
	assign sts.last_glyph = ({1'b0, g_q} == n_glyphs - 1'b1);
	assign sts.pipe_empty = !v_s1 && !v_s2;
	assign row_len = (blocks_per_row == '0) ? gbnm_pkg::CNT_W'(1) : blocks_per_row;

	// Loads go straight into the stores at the accept edge.
	assign pstore_we = cmd.take_in && in_word.command == gbnm_pkg::CMD_LOAD_PIXEL &&
		32'(in_word.pixel_index) < gbnm_pkg::BLOCK_PIXELS &&
		32'(in_word.glyph_index) < gbnm_pkg::MAX_GLYPHS;
	assign cstore_we = cmd.take_in && in_word.command == gbnm_pkg::CMD_LOAD_CODE &&
		32'(in_word.glyph_index) < gbnm_pkg::MAX_GLYPHS;
	assign p_waddr = {in_word.glyph_index[GW-1:0], in_word.pixel_index[PW-1:0]};
	assign p_raddr = {g_q, word_q.pixel_index[PW-1:0]};
	assign sum_raddr = g_q;
	assign code_raddr = best_q;

	gbnm_ram #(.WIDTH(8), .DEPTH(gbnm_pkg::PSTORE_DEPTH)) u_pix (
		.clk(clk), .we(pstore_we), .waddr(p_waddr), .wdata(in_word.pixel_value),
		.raddr(p_raddr), .rdata(gp_rd));
	gbnm_ram #(.WIDTH(gbnm_pkg::CODE_W), .DEPTH(gbnm_pkg::MAX_GLYPHS)) u_code (
		.clk(clk), .we(cstore_we), .waddr(in_word.glyph_index[GW-1:0]),
		.wdata(in_word.code_point), .raddr(code_raddr), .rdata(code_rd));
	gbnm_ram #(.WIDTH(SW), .DEPTH(gbnm_pkg::MAX_GLYPHS)) u_sum (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(sum_raddr), .rdata(sum_rd));

	assign sq = 16'(diff_s2) * 16'(diff_s2);
	assign sum_new = {1'b0, sum_s2} + (SW+1)'(sq);
	assign sum_we = v_s2;
	assign sum_waddr = g_s2;
	assign sum_wdata = sum_new[SW] ? {SW{1'b1}} : sum_new[SW-1:0];
	assign mean_rd = sum_ok_s1 ? sum_rd[SW-1:PW] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			p_s1 <= 1'b0;
			bcount_q <= '0;
			for (int i = 0; i < gbnm_pkg::MAX_GLYPHS; i++) sum_valid_q[i] <= 1'b0;
		end else begin
			v_s1 <= (cmd.sweep_step && !cmd.pick_clear && pix_ok_q &&
				word_q.command == gbnm_pkg::CMD_SOURCE && !pick_q);
			v_s2 <= v_s1;
			p_s1 <= cmd.sweep_step && pick_q;
			if (v_s2) sum_valid_q[g_s2] <= 1'b1;
			// Clear all sums and step the block count once the block's result is out.
			if (cmd.out_load) begin
				for (int i = 0; i < gbnm_pkg::MAX_GLYPHS; i++) sum_valid_q[i] <= 1'b0;
				if (bcount_q >= row_len) bcount_q <= gbnm_pkg::CNT_W'(1);
				else bcount_q <= bcount_q + 1'b1;
			end
			if (cmd.take_in && in_word.command == gbnm_pkg::CMD_SOURCE &&
				in_word.picture_start) bcount_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pick_q <= 1'b0;
		else if (cmd.pick_clear) pick_q <= 1'b1;
		else if (cmd.out_load) pick_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			word_q <= in_word;
			pix_ok_q <= 32'(in_word.pixel_index) < gbnm_pkg::BLOCK_PIXELS;
		end
		if (cmd.sweep_start) g_q <= '0;
		else if (cmd.sweep_step && !sts.last_glyph) g_q <= g_q + 1'b1;
		g_s1 <= g_q;
		pv_s1 <= word_q.pixel_value;
		sum_ok_s1 <= sum_valid_q[g_q];
		g_s2 <= g_s1;
		diff_s2 <= (pv_s1 > gp_rd) ? pv_s1 - gp_rd : gp_rd - pv_s1;
		sum_s2 <= sum_ok_s1 ? sum_rd : '0;
		if (cmd.pick_clear) best_any_q <= 1'b0;
		else if (p_s1 && (!best_any_q || mean_rd < best_mean_q)) begin
			best_any_q <= 1'b1;
			best_mean_q <= mean_rd;
			best_q <= g_s1;
		end
		if (cmd.out_load) begin
			out_word.best_glyph <= 7'(best_q);
			out_word.best_code_point <= code_rd;
			out_word.mean_error <= (best_mean_q > (SW-PW)'(16'hFFFF)) ?
				16'hFFFF : 16'(best_mean_q);
			out_word.new_line <= (bcount_q >= row_len);
		end
	end
endmodule
